// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file of the parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define AST_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rpsp assertion failed");

// a stalled signal keeps its value until taken
`define AST_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
  `AST_PROP(lbl, clk, rst_n, (vld && !rdy) |=> $stable(sig))

`endif

// ----- hdl/rpsp_pkg.sv -----
// package: types, constants and helpers of the palette stream parser
package rpsp_pkg;

  localparam int MaxEntries = 256;
  localparam int UsableW    = $clog2(MaxEntries + 1);
  localparam int PosW       = 11;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);
  localparam logic [7:0] AlphaOpaque = 8'd255;

  typedef enum logic [2:0] {
    ST_ENTRY         = 3'd0,
    ST_DONE          = 3'd1,
    ST_SHORT         = 3'd2,
    ST_BAD_RIFF      = 3'd3,
    ST_BAD_PAL       = 3'd4,
    ST_BAD_DATA      = 3'd5,
    ST_TOO_MANY      = 3'd6,
    ST_SHORT_ENTRIES = 3'd7
  } status_e;

  typedef struct packed {
    logic       has_entry;
    logic       has_status;
    status_e    status;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } cmd_t;

  // expected header bytes; positions 4..7 are don't care
  function automatic logic [7:0] magic_byte(input logic [3:0] pos);
    logic [7:0] m;
    case (pos)
      4'd0:    m = 8'h52;
      4'd1:    m = 8'h49;
      4'd2:    m = 8'h46;
      4'd3:    m = 8'h46;
      4'd8:    m = 8'h50;
      4'd9:    m = 8'h41;
      4'd10:   m = 8'h4c;
      4'd11:   m = 8'h20;
      4'd12:   m = 8'h64;
      4'd13:   m = 8'h61;
      4'd14:   m = 8'h74;
      4'd15:   m = 8'h61;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/rpsp_if.sv -----
// handshake channels: byte requests in, result requests out
interface rpsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       final_byte;
  modport source (output valid, output file_byte, output final_byte, input ready);
  modport sink (input valid, input file_byte, input final_byte, output ready);
endinterface

interface rpsp_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       end_of_run;
  modport source (output valid, output status, output entry_index, output red,
                  output green, output blue, output alpha, output end_of_run,
                  input ready);
  modport sink (input valid, input status, input entry_index, input red,
                input green, input blue, input alpha, input end_of_run,
                output ready);
endinterface

// ----- hdl/rpsp_front.sv -----
// front: takes bytes, tracks the header and builds entry and status commands
module rpsp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpsp_byte_if.sink        byte_in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output rpsp_pkg::cmd_t   cmd_o
);
  import rpsp_pkg::*;

  logic [PosW-1:0]    pos_q, pos_d;
  status_e            err_q, err_d;
  logic [31:0]        chunk_q, chunk_d;
  logic [7:0]         comp_q, comp_d;
  logic [15:0]        decl_q, decl_d;
  logic [UsableW-1:0] usable_q, usable_d;
  logic [23:0]        part_q, part_d;

  logic               fire;
  logic [7:0]         b;
  logic [15:0]        decl_full;
  logic [29:0]        avail;
  logic [PosW-1:0]    rel;
  logic [PosW-3:0]    idx;
  logic [PosW:0]      size;
  logic [PosW:0]      need;
  cmd_t               cmd;

  assign byte_in_i.ready = !q_full_i;
  assign fire = byte_in_i.valid && !q_full_i;
  assign b    = byte_in_i.file_byte;
  assign rel  = pos_q - PosW'(24);
  assign idx  = rel[PosW-1:2];
  assign decl_full = {b, decl_q[7:0]};
  assign avail = (chunk_q > 32'd4) ? 30'((chunk_q - 32'd4) >> 2) : 30'd0;

  always_comb begin
    pos_d    = pos_q;
    err_d    = err_q;
    chunk_d  = chunk_q;
    comp_d   = comp_q;
    decl_d   = decl_q;
    usable_d = usable_q;
    part_d   = part_q;
    cmd      = '0;
    size     = '0;
    need     = '0;
    if (fire) begin
      if (pos_q < PosW'(4)) begin
        if (b != magic_byte(pos_q[3:0]) && err_q == ST_ENTRY) err_d = ST_BAD_RIFF;
      end else if (pos_q >= PosW'(8) && pos_q < PosW'(12)) begin
        if (b != magic_byte(pos_q[3:0]) && err_q == ST_ENTRY) err_d = ST_BAD_PAL;
      end else if (pos_q >= PosW'(12) && pos_q < PosW'(16)) begin
        if (b != magic_byte(pos_q[3:0]) && err_q == ST_ENTRY) err_d = ST_BAD_DATA;
      end else if (pos_q >= PosW'(16) && pos_q < PosW'(20)) begin
        case (pos_q[1:0])
          2'd0:    chunk_d[7:0]   = b;
          2'd1:    chunk_d[15:8]  = b;
          2'd2:    chunk_d[23:16] = b;
          default: chunk_d[31:24] = b;
        endcase
      end else if (pos_q == PosW'(21)) begin
        comp_d = b;
      end else if (pos_q == PosW'(22)) begin
        decl_d = {8'h00, b};
      end else if (pos_q == PosW'(23)) begin
        decl_d = decl_full;
        if (decl_full > 16'(MaxEntries)) begin
          if (err_q == ST_ENTRY) err_d = ST_TOO_MANY;
          usable_d = '0;
        end else if (avail < {14'd0, decl_full}) begin
          usable_d = UsableW'(avail);
        end else begin
          usable_d = UsableW'(decl_full);
        end
      end else if (pos_q >= PosW'(24) && err_q == ST_ENTRY) begin
        if ({1'b0, idx} < (PosW-1)'(usable_q)) begin
          case (rel[1:0])
            2'd0:    part_d[7:0]   = b;
            2'd1:    part_d[15:8]  = b;
            2'd2:    part_d[23:16] = b;
            default: begin
              cmd.has_entry = 1'b1;
              cmd.idx       = idx[7:0];
              cmd.red       = part_q[7:0];
              cmd.green     = part_q[15:8];
              cmd.blue      = part_q[23:16];
              cmd.alpha     = (comp_q == 8'd4) ? b : AlphaOpaque;
              part_d        = '0;
            end
          endcase
        end
      end

      if (pos_q != PosMax) pos_d = pos_q + PosW'(1);

      if (byte_in_i.final_byte) begin
        size = {1'b0, pos_q} + (PosW+1)'(1);
        need = (PosW+1)'(24) + (PosW+1)'({usable_d, 2'b00});
        cmd.has_status = 1'b1;
        if (size < (PosW+1)'(24))     cmd.status = ST_SHORT;
        else if (err_d != ST_ENTRY)   cmd.status = err_d;
        else if (size < need)         cmd.status = ST_SHORT_ENTRIES;
        else                          cmd.status = ST_DONE;
        // file over: start the next one from a clean state
        pos_d    = '0;
        err_d    = ST_ENTRY;
        chunk_d  = '0;
        comp_d   = '0;
        decl_d   = '0;
        usable_d = '0;
        part_d   = '0;
      end
    end
  end

  assign push_o = cmd.has_entry || cmd.has_status;
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      err_q    <= ST_ENTRY;
      chunk_q  <= '0;
      comp_q   <= '0;
      decl_q   <= '0;
      usable_q <= '0;
      part_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      err_q    <= err_d;
      chunk_q  <= chunk_d;
      comp_q   <= comp_d;
      decl_q   <= decl_d;
      usable_q <= usable_d;
      part_q   <= part_d;
    end
  end

endmodule

// ----- hdl/rpsp_queue.sv -----
// small command fifo between front and back
module rpsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rpsp_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output rpsp_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import rpsp_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QCntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/rpsp_back.sv -----
// back: turns queued commands into result requests through an output register
module rpsp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rpsp_pkg::cmd_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  rpsp_result_if.source  result_o
);
  import rpsp_pkg::*;

  logic       valid_q, valid_d;
  logic       half_q, half_d;
  logic       load;
  logic       send_entry;
  logic [2:0] status_q, status_d;
  logic [7:0] idx_q, idx_d, red_q, red_d, green_q, green_d;
  logic [7:0] blue_q, blue_d, alpha_q, alpha_d;
  logic       eor_q, eor_d;

  assign load       = !empty_i && (!valid_q || result_o.ready);
  assign send_entry = head_i.has_entry && !half_q;

  always_comb begin
    valid_d  = valid_q && !result_o.ready;
    half_d   = half_q;
    pop_o    = 1'b0;
    status_d = status_q;
    idx_d    = idx_q;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    alpha_d  = alpha_q;
    eor_d    = eor_q;
    if (load) begin
      valid_d = 1'b1;
      if (send_entry) begin
        status_d = ST_ENTRY;
        idx_d    = head_i.idx;
        red_d    = head_i.red;
        green_d  = head_i.green;
        blue_d   = head_i.blue;
        alpha_d  = head_i.alpha;
        eor_d    = 1'b0;
        // entry and status on the same byte: status goes out next
        half_d   = head_i.has_status;
        pop_o    = !head_i.has_status;
      end else begin
        status_d = head_i.status;
        idx_d    = '0;
        red_d    = '0;
        green_d  = '0;
        blue_d   = '0;
        alpha_d  = '0;
        eor_d    = 1'b1;
        half_d   = 1'b0;
        pop_o    = 1'b1;
      end
    end
  end

  assign result_o.valid       = valid_q;
  assign result_o.status      = status_q;
  assign result_o.entry_index = idx_q;
  assign result_o.red         = red_q;
  assign result_o.green       = green_q;
  assign result_o.blue        = blue_q;
  assign result_o.alpha       = alpha_q;
  assign result_o.end_of_run  = eor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    idx_q    <= idx_d;
    red_q    <= red_d;
    green_q  <= green_d;
    blue_q   <= blue_d;
    alpha_q  <= alpha_d;
    eor_q    <= eor_d;
  end

endmodule

// ----- hdl/riff_palette_stream_parser_unit.sv -----
// top level of the riff palette stream parser
// usage:
// - byte_in_i carries one byte of a palette file per request, with
//   final_byte high on the last byte; the next byte then starts a new file
// - result_o carries one request per palette entry (status entry) and one
//   status request with end_of_run high at the end of each file
// - entries already delivered must be dropped by the receiver when the
//   closing status is an error
// throughput: one byte per cycle while the fifo has room; a final byte that also
//   completes an entry yields two results, the entry and then the status
// path: a byte's command is written into the fifo on the accepting edge,
//   then loaded into the output register
// stall: when the receiver holds ready low the output register and the
//   four-deep command fifo absorb results; bytes that make no result keep
//   flowing, and byte_in_i.ready drops only when the fifo is full
// reset: asynchronous, clears header tracking, fifo and output valid;
//   the block is ready for bytes as soon as reset is released
module riff_palette_stream_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  rpsp_byte_if.sink     byte_in_i,
  rpsp_result_if.source result_o
);
  import rpsp_pkg::*;

  // front to fifo
  logic push;
  cmd_t push_cmd;

  // fifo to back
  cmd_t head;
  logic q_empty;
  logic q_full;
  logic pop;

  // header parsing and entry assembly
  rpsp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in_i (byte_in_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // decouples the byte side from the result side
  rpsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // result formatting and output register
  rpsp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (q_empty),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

// ----- hdl/rpsp_checker.sv -----
// port-level checks on the result channel of the parser
`include "assert_macros.svh"

module rpsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] status_i,
  input logic [7:0] entry_index_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i,
  input logic       end_of_run_i
);
  import rpsp_pkg::*;

  `AST_HOLD(a_valid_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_valid_i)
  `AST_HOLD(a_status_hold, clk_i, rst_ni, out_valid_i, out_ready_i, status_i)
  `AST_PROP(a_eor_iff_status, clk_i, rst_ni, out_valid_i |-> ((status_i == ST_ENTRY) != end_of_run_i))
  `AST_PROP(a_status_zero_fields, clk_i, rst_ni, (out_valid_i && end_of_run_i) |-> ((entry_index_i == 8'd0) && (red_i == 8'd0) && (green_i == 8'd0) && (blue_i == 8'd0) && (alpha_i == 8'd0)))

endmodule

bind riff_palette_stream_parser_unit rpsp_checker u_rpsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .status_i      (result_o.status),
  .entry_index_i (result_o.entry_index),
  .red_i         (result_o.red),
  .green_i       (result_o.green),
  .blue_i        (result_o.blue),
  .alpha_i       (result_o.alpha),
  .end_of_run_i  (result_o.end_of_run)
);

// ----- dv/rpsp_scoreboard_pkg.sv -----
// palette result type, header magic lookup and the byte-level scoreboard
`timescale 1ns / 100ps
package rpsp_scoreboard_pkg;
  import rpsp_pkg::*;

  typedef struct packed {
    status_e    status;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       eor;
  } palette_result_t;

  // "RIFF" .... "PAL " "data"; bytes 4..7 carry the riff length
  function automatic logic [7:0] hdr_magic(input int unsigned p);
    case (p)
      0, 1:    return 8'h52 + ((p == 1) ? 8'hf7 : 8'h00);
      2, 3:    return 8'h46;
      8:       return 8'h50;
      9:       return 8'h41;
      10:      return 8'h4c;
      11:      return 8'h20;
      12:      return 8'h64;
      13, 15:  return 8'h61;
      14:      return 8'h74;
      default: return 8'h00;
    endcase
  endfunction

  class palette_scoreboard;
    logic [PosW-1:0]    position;
    logic               have_error;
    status_e            first_err;
    logic [31:0]        chunk_len;
    logic [7:0]         comps;
    logic [15:0]        declared;
    logic [UsableW-1:0] usable;
    logic [23:0]        partial;
    palette_result_t    expected_q[$];
    int                 mismatches;
    int                 entries_seen;
    int                 status_hits[8];

    function new();
      mismatches   = 0;
      entries_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      clear_file();
    endfunction

    function void clear_file();
      position   = '0;
      have_error = 1'b0;
      first_err  = ST_ENTRY;
      chunk_len  = '0;
      comps      = '0;
      declared   = '0;
      usable     = '0;
      partial    = '0;
    endfunction

    function void flag_error(input status_e code);
      if (!have_error) begin
        have_error = 1'b1;
        first_err  = code;
      end
    endfunction

    function void push_result(input status_e st, input logic [7:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a,
                              input logic eor);
      palette_result_t res;
      res.status = st;
      res.idx    = idx;
      res.red    = r;
      res.green  = g;
      res.blue   = b;
      res.alpha  = a;
      res.eor    = eor;
      expected_q.insert(expected_q.size(), res);
    endfunction

    // one accepted byte request: update the parser state, queue what it yields
    function void note_byte(input logic [7:0] b, input logic fin);
      int unsigned p;
      int unsigned rel;
      int unsigned slot;
      int unsigned sub;
      int unsigned avail;
      int unsigned size;
      status_e     closing;
      p = position;
      if (p < 4) begin
        if (b != hdr_magic(p)) flag_error(ST_BAD_RIFF);
      end else if (p >= 8 && p < 12) begin
        if (b != hdr_magic(p)) flag_error(ST_BAD_PAL);
      end else if (p >= 12 && p < 16) begin
        if (b != hdr_magic(p)) flag_error(ST_BAD_DATA);
      end else if (p >= 16 && p < 20) begin
        chunk_len[(p - 16) * 8 +: 8] = b;
      end else if (p == 21) begin
        comps = b;
      end else if (p == 22) begin
        declared = {8'h00, b};
      end else if (p == 23) begin
        declared[15:8] = b;
        if (declared > MaxEntries) begin
          flag_error(ST_TOO_MANY);
          usable = '0;
        end else begin
          avail  = (chunk_len > 32'd4) ? (chunk_len - 32'd4) / 4 : 0;
          usable = UsableW'((avail < declared) ? avail : 32'(declared));
        end
      end else if (p >= 24 && !have_error) begin
        rel  = p - 24;
        slot = rel >> 2;
        sub  = rel & 3;
        if (slot < usable) begin
          if (sub < 3) begin
            partial[sub * 8 +: 8] = b;
          end else begin
            push_result(ST_ENTRY, slot[7:0], partial[7:0], partial[15:8],
                        partial[23:16], (comps == 8'd4) ? b : AlphaOpaque, 1'b0);
            partial = '0;
          end
        end
      end
      if (position != PosMax) position++;
      if (fin) begin
        size = p + 1;
        if (size < 24) closing = ST_SHORT;
        else if (have_error) closing = first_err;
        else if (size < 24 + usable * 4) closing = ST_SHORT_ENTRIES;
        else closing = ST_DONE;
        push_result(closing, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        clear_file();
      end
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input palette_result_t got);
      palette_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d index %0d", got.status, got.idx);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("entry_index", want.idx, got.idx);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("end_of_run", 8'(want.eor), 8'(got.eor));
      if (want.eor) status_hits[want.status]++;
      else entries_seen++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ----- dv/tb_riff_palette_stream_parser_unit.sv -----
// testbench of the riff palette stream parser: random palette files, scoreboard check
`timescale 1ns / 100ps
module tb_riff_palette_stream_parser_unit;
  import rpsp_pkg::*;
  import rpsp_scoreboard_pkg::*;

  localparam int RandomBytes   = 480;
  localparam int BigEntries    = 40;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 20;

  logic clk_i;
  logic rst_ni;

  rpsp_byte_if   byte_ch();
  rpsp_result_if res_ch();

  riff_palette_stream_parser_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in_i (byte_ch),
    .result_o  (res_ch)
  );

  palette_scoreboard sb;

  // bytes of the file being built, sent front to back
  logic [7:0] file_q[$];
  int         files_sent   = 0;
  int         bytes_sent   = 0;
  int         idle_cycles  = 0;
  // stretches where a side never idles
  logic       src_steady   = 1'b0;
  logic       sink_steady  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // append one byte to the file being built
  function automatic void add_byte(input logic [7:0] v);
    file_q.insert(file_q.size(), v);
  endfunction

  // 24-byte header with good magics; riff length and unknown byte are random
  task automatic make_header(input logic [31:0] clen, input logic [7:0] comp,
                             input logic [15:0] cnt);
    int p;
    file_q.delete();
    for (p = 0; p < 16; p++) begin
      if (p >= 4 && p < 8) add_byte(rand_byte());
      else add_byte(hdr_magic(p));
    end
    for (p = 0; p < 4; p++) add_byte(clen[p * 8 +: 8]);
    add_byte(rand_byte());
    add_byte(comp);
    add_byte(cnt[7:0]);
    add_byte(cnt[15:8]);
  endtask

  // well-formed header with random content; body length near what the
  // chunk length and the entry count allow
  task automatic make_palette_file();
    int unsigned cnt;
    int unsigned usable_n;
    int unsigned avail;
    int unsigned body;
    int unsigned r;
    int unsigned i;
    logic [31:0] clen;
    logic [7:0]  comp;
    r = $urandom_range(0, 99);
    if (r < 85) cnt = $urandom_range(0, 6);
    else if (r < 92) cnt = MaxEntries;
    else cnt = $urandom_range(MaxEntries + 1, 65535);
    r = $urandom_range(0, 99);
    // a full-size count gets a small chunk so the cap keeps the file short
    if (cnt == MaxEntries) clen = $urandom_range(0, 40);
    else if (cnt > MaxEntries || (r >= 80 && r < 90)) clen = $urandom;
    else if (r < 50) clen = 4 + 4 * cnt;
    else if (r < 65) clen = $urandom_range(0, 8);
    else if (r < 80) clen = $urandom_range(0, 4 * cnt + 3);
    else clen = 4 + 4 * cnt + $urandom_range(1, 11);
    if (cnt > MaxEntries) begin
      usable_n = 0;
    end else begin
      avail    = (clen > 4) ? (clen - 4) / 4 : 0;
      usable_n = (avail < cnt) ? avail : cnt;
    end
    r = $urandom_range(0, 99);
    if (r < 50) comp = 8'd4;
    else if (r < 80) comp = 8'd3;
    else comp = rand_byte();
    make_header(clen, comp, 16'(cnt));
    // exact body, cut short inside the entries, or with surplus bytes
    r = $urandom_range(0, 99);
    if (r < 70) body = 4 * usable_n;
    else if (r < 85 && usable_n > 0) body = $urandom_range(0, 4 * usable_n - 1);
    else body = 4 * usable_n + $urandom_range(1, 6);
    for (i = 0; i < body; i++) add_byte(rand_byte());
  endtask

  // mix of good files, bad magics, truncated headers and plain noise
  task automatic make_random_file();
    int unsigned r;
    int unsigned n;
    int unsigned slot;
    int unsigned pos;
    int unsigned cut;
    logic [7:0]  flip;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      file_q.delete();
      n = $urandom_range(1, 40);
      repeat (n) add_byte(rand_byte());
    end else begin
      make_palette_file();
      // one or two broken magic bytes; two checks that the first one wins
      if ((r >= 55 && r < 80) || r >= 93) begin
        n = $urandom_range(1, 2);
        repeat (n) begin
          slot = $urandom_range(0, 11);
          pos  = (slot < 4) ? slot : slot + 4;
          flip = 8'($urandom_range(1, 255));
          file_q[pos] = hdr_magic(pos) ^ flip;
        end
      end
      // file ends inside the header
      if (r >= 80) begin
        cut = $urandom_range(1, 23);
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
    end
  endtask

  // a longer good file: every entry present, then a few surplus bytes
  task automatic make_big_file();
    int i;
    make_header(32'd4 + 32'd4 * 32'(BigEntries), 8'd4, 16'(BigEntries));
    for (i = 0; i < 4 * BigEntries + 5; i++) add_byte(rand_byte());
  endtask

  // one byte request; valid stays high across back-to-back requests
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      byte_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    byte_ch.valid      <= 1'b1;
    byte_ch.file_byte  <= b;
    byte_ch.final_byte <= fin;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_file();
    int i;
    src_steady = ($urandom_range(0, 3) == 0);
    for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  // result receiver: random stall per result, occasional stretches with none
  initial begin : result_sink
    int stall;
    palette_result_t got;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk_i);
        res_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      got.status = status_e'(res_ch.status);
      got.idx    = res_ch.entry_index;
      got.red    = res_ch.red;
      got.green  = res_ch.green;
      got.blue   = res_ch.blue;
      got.alpha  = res_ch.alpha;
      got.eor    = res_ch.end_of_run;
      sb.check_result(got);
    end
  end

  // watchdog: too long without a request moving on either side
  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int  random_bytes;
    int  file_no;
    int  big_at;
    logic big_done;
    rst_ni             = 1'b0;
    byte_ch.valid      = 1'b0;
    byte_ch.file_byte  = 8'h00;
    byte_ch.final_byte = 1'b0;
    sb                 = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: one-byte files at both byte extremes, then a minimal good file
    // whose final byte completes its only entry (entry and status together)
    file_q.delete();
    add_byte(8'h00);
    send_file();
    file_q.delete();
    add_byte(8'hff);
    send_file();
    make_header(32'd8, 8'd4, 16'd1);
    add_byte(8'h00);
    add_byte(8'h7f);
    add_byte(8'h80);
    add_byte(8'hff);
    send_file();

    // random files; the big one goes in at a random spot
    random_bytes = 0;
    file_no      = 0;
    big_done     = 1'b0;
    big_at       = $urandom_range(0, 15);
    while (random_bytes < RandomBytes) begin
      if (file_no == big_at) begin
        make_big_file();
        send_file();
        big_done = 1'b1;
      end
      make_random_file();
      random_bytes += file_q.size();
      send_file();
      file_no++;
    end
    if (!big_done) begin
      make_big_file();
      send_file();
    end
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;

    // drain, then give the pipe time to show any extra result
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d files, %0d bytes, %0d palette entries checked",
             files_sent, bytes_sent, sb.entries_seen);
    $display("closing: done %0d short %0d riff %0d pal %0d data %0d count %0d entries %0d",
             sb.status_hits[ST_DONE], sb.status_hits[ST_SHORT],
             sb.status_hits[ST_BAD_RIFF], sb.status_hits[ST_BAD_PAL],
             sb.status_hits[ST_BAD_DATA], sb.status_hits[ST_TOO_MANY],
             sb.status_hits[ST_SHORT_ENTRIES]);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rpsp_pkg.sv
hdl/rpsp_if.sv
hdl/rpsp_front.sv
hdl/rpsp_queue.sv
hdl/rpsp_back.sv
hdl/riff_palette_stream_parser_unit.sv
hdl/rpsp_checker.sv
dv/rpsp_scoreboard_pkg.sv
dv/tb_riff_palette_stream_parser_unit.sv
